// ----- rtl/inms_pkg.sv -----
package inms_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = IDX_W + 1;

    localparam logic REG_IOU_LIMIT = 1'b0;
    localparam logic REG_MODE      = 1'b1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    localparam logic MODE_GREEDY = 1'b0;

    typedef struct packed {
        logic        command;
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] box_score;
        logic [9:0]  box_class;
    } item_t;

    typedef struct packed {
        logic [15:0] kept_left;
        logic [15:0] kept_top;
        logic [15:0] kept_width;
        logic [15:0] kept_height;
        logic [15:0] kept_score;
        logic [9:0]  kept_class;
        logic        kept_valid;
        logic        dropped_some;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] score;
        logic [9:0]  label;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] a_addr;
        logic [IDX_W-1:0] b_addr;
        logic             issue;
        logic             pair_mode;
        logic [15:0]      iou_limit;
        logic             capture;
        logic             emit;
        logic             emit_valid;
        logic             emit_last;
        logic             dropped;
    } cmd_t;

    typedef struct packed {
        logic [15:0]      b_score;
        logic             hit_valid;
        logic             hit;
        logic [IDX_W-1:0] hit_tag;
        logic             pipe_busy;
    } stat_t;

endpackage

// ----- rtl/inms_ram.sv -----
module inms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/inms_datapath.sv -----
module inms_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  inms_pkg::item_t        item,
    input  inms_pkg::cmd_t         cmd,
    output inms_pkg::stat_t        stat,
    output inms_pkg::result_t      result,
    output logic                   result_valid
);

    inms_pkg::entry_t wr_entry;
    logic [inms_pkg::ENTRY_W-1:0] a_raw;
    logic [inms_pkg::ENTRY_W-1:0] b_raw;
    inms_pkg::entry_t ea;
    inms_pkg::entry_t eb;

    assign wr_entry = '{left: item.box_left, top: item.box_top, width: item.box_width,
                        height: item.box_height, score: item.box_score,
                        label: item.box_class};
    assign ea = inms_pkg::entry_t'(a_raw);
    assign eb = inms_pkg::entry_t'(b_raw);

    // two copies of the store give two read ports
    inms_ram #(.WIDTH(inms_pkg::ENTRY_W), .DEPTH(inms_pkg::MAX_BOXES)) u_ram_a (
        .clk(clk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr), .wr_data(wr_entry),
        .rd_addr(cmd.a_addr), .rd_data(a_raw)
    );

    inms_ram #(.WIDTH(inms_pkg::ENTRY_W), .DEPTH(inms_pkg::MAX_BOXES)) u_ram_b (
        .clk(clk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr), .wr_data(wr_entry),
        .rd_addr(cmd.b_addr), .rd_data(b_raw)
    );

    logic [5:0] v_reg;
    logic [inms_pkg::IDX_W-1:0] tag0_reg, tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic need1_reg, need2_reg, need3_reg, need4_reg, need5_reg;

    logic [16:0] ra_reg, rb_reg, ba_reg, bb_reg;
    logic [15:0] lox_reg, loy_reg;
    logic [31:0] area_a_reg, area_b_reg;
    logic [15:0] dx_reg, dy_reg;
    logic [32:0] sum2_reg, sum3_reg;
    logic [31:0] inter3_reg, inter4_reg, inter5_reg;
    logic [32:0] uni_reg;
    logic        zero5_reg;
    logic [48:0] prod_reg;
    logic        hit_reg;

    logic        need;
    logic [16:0] hix, hiy;
    logic        issue_d_reg;

    assign need = !cmd.pair_mode || (ea.label == eb.label && ea.score < eb.score);
    assign hix = (ra_reg < rb_reg) ? ra_reg : rb_reg;
    assign hiy = (ba_reg < bb_reg) ? ba_reg : bb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_d_reg <= 1'b0;
            v_reg       <= '0;
        end
        else
        begin
            issue_d_reg <= cmd.issue;
            v_reg       <= {v_reg[4:0], issue_d_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        tag0_reg <= cmd.b_addr;
        // stage 1: edges, near corner and areas
        ra_reg     <= {1'b0, ea.left} + {1'b0, ea.width};
        rb_reg     <= {1'b0, eb.left} + {1'b0, eb.width};
        ba_reg     <= {1'b0, ea.top} + {1'b0, ea.height};
        bb_reg     <= {1'b0, eb.top} + {1'b0, eb.height};
        lox_reg    <= (ea.left > eb.left) ? ea.left : eb.left;
        loy_reg    <= (ea.top > eb.top) ? ea.top : eb.top;
        area_a_reg <= ea.width * ea.height;
        area_b_reg <= eb.width * eb.height;
        need1_reg  <= need;
        tag1_reg   <= tag0_reg;
        // stage 2: overlap extents, clamped at zero
        dx_reg    <= (hix > {1'b0, lox_reg}) ? 16'(hix - {1'b0, lox_reg}) : 16'd0;
        dy_reg    <= (hiy > {1'b0, loy_reg}) ? 16'(hiy - {1'b0, loy_reg}) : 16'd0;
        sum2_reg  <= {1'b0, area_a_reg} + {1'b0, area_b_reg};
        need2_reg <= need1_reg;
        tag2_reg  <= tag1_reg;
        // stage 3: intersection
        inter3_reg <= dx_reg * dy_reg;
        sum3_reg   <= sum2_reg;
        need3_reg  <= need2_reg;
        tag3_reg   <= tag2_reg;
        // stage 4: union
        uni_reg    <= sum3_reg - {1'b0, inter3_reg};
        inter4_reg <= inter3_reg;
        need4_reg  <= need3_reg;
        tag4_reg   <= tag3_reg;
        // stage 5: threshold times union
        prod_reg   <= cmd.iou_limit * uni_reg;
        zero5_reg  <= (uni_reg == 33'd0);
        inter5_reg <= inter4_reg;
        need5_reg  <= need4_reg;
        tag5_reg   <= tag4_reg;
        // stage 6: compare
        hit_reg  <= need5_reg && !zero5_reg && ({1'b0, inter5_reg, 16'd0} >= prod_reg);
    end

    logic [inms_pkg::IDX_W-1:0] tag6_reg;

    always_ff @(posedge clk)
    begin
        tag6_reg <= tag5_reg;
    end

    assign stat.b_score   = eb.score;
    assign stat.hit_valid = v_reg[5];
    assign stat.hit       = hit_reg;
    assign stat.hit_tag   = tag6_reg;
    assign stat.pipe_busy = issue_d_reg || (v_reg != '0);

    // hold the last kept box until the next one shows whether it ends the run
    inms_pkg::entry_t pend_reg;
    logic             out_valid_reg;
    inms_pkg::result_t out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pend_reg <= ea;
        end
        if (cmd.emit)
        begin
            out_reg.kept_left    <= cmd.emit_valid ? pend_reg.left : 16'd0;
            out_reg.kept_top     <= cmd.emit_valid ? pend_reg.top : 16'd0;
            out_reg.kept_width   <= cmd.emit_valid ? pend_reg.width : 16'd0;
            out_reg.kept_height  <= cmd.emit_valid ? pend_reg.height : 16'd0;
            out_reg.kept_score   <= cmd.emit_valid ? pend_reg.score : 16'd0;
            out_reg.kept_class   <= cmd.emit_valid ? pend_reg.label : 10'd0;
            out_reg.kept_valid   <= cmd.emit_valid;
            out_reg.dropped_some <= cmd.dropped;
            out_reg.last_of_run  <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

// ----- rtl/inms_ctrl.sv -----
module inms_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  inms_pkg::item_t        item,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_data,
    input  inms_pkg::stat_t        stat,
    output inms_pkg::cmd_t         cmd,
    output logic                   busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_PICK   = 3'd2;
    localparam logic [2:0] S_TEST   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    localparam int N = inms_pkg::MAX_BOXES;
    localparam int IW = inms_pkg::IDX_W;
    localparam int CW = inms_pkg::CNT_W;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] j_reg, j_next;
    logic [IW-1:0] jd_reg;
    logic          vd_reg, vd_next;
    logic [IW-1:0] a_reg, a_next;
    logic [IW-1:0] best_reg, best_next;
    logic          best_v_reg, best_v_next;
    logic [15:0]   best_s_reg, best_s_next;
    logic          ovf_reg, ovf_next;
    logic          bad_reg, bad_next;
    logic          pend_v_reg, pend_v_next;
    logic [N-1:0]  vis_reg, vis_next;
    logic [N-1:0]  supp_reg, supp_next;
    logic          mode_reg;
    logic [15:0]   lim_reg;
    logic          accept;
    logic          issuing;

    assign accept  = start && (state_reg == S_IDLE);
    assign issuing = (j_reg < n_reg);
    assign busy    = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        j_next      = j_reg;
        vd_next     = 1'b0;
        a_next      = a_reg;
        best_next   = best_reg;
        best_v_next = best_v_reg;
        best_s_next = best_s_reg;
        ovf_next    = ovf_reg;
        bad_next    = bad_reg;
        pend_v_next = pend_v_reg;
        vis_next    = vis_reg;
        supp_next   = supp_reg;

        cmd            = '0;
        cmd.wr_addr    = n_reg[IW-1:0];
        cmd.a_addr     = a_reg;
        cmd.b_addr     = j_reg[IW-1:0];
        cmd.pair_mode  = (mode_reg != inms_pkg::MODE_GREEDY);
        cmd.iou_limit  = lim_reg;
        cmd.dropped    = ovf_reg;
        cmd.emit_valid = pend_v_reg;

        if (stat.hit_valid && stat.hit)
        begin
            supp_next[stat.hit_tag] = 1'b1;
            bad_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == inms_pkg::CMD_LOAD)
                    begin
                        if (n_reg < CW'(N))
                        begin
                            cmd.wr_en = 1'b1;
                            n_next    = n_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        j_next      = '0;
                        a_next      = '0;
                        best_v_next = 1'b0;
                        if (n_reg == '0)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (mode_reg == inms_pkg::MODE_GREEDY)
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_PICK;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // find the highest-score box still open, lowest index on ties
                if (issuing)
                begin
                    j_next  = j_reg + 1'b1;
                    vd_next = 1'b1;
                end
                if (vd_reg && !vis_reg[jd_reg] && !supp_reg[jd_reg] &&
                    (!best_v_reg || stat.b_score > best_s_reg))
                begin
                    best_next   = jd_reg;
                    best_v_next = 1'b1;
                    best_s_next = stat.b_score;
                end
                if (!issuing && !vd_reg)
                begin
                    if (!best_v_reg || best_s_reg == 16'd0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        a_next             = best_reg;
                        vis_next[best_reg] = 1'b1;
                        state_next         = S_PICK;
                    end
                end
            end
            S_PICK:
            begin
                j_next     = '0;
                bad_next   = 1'b0;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                cmd.issue = 1'b1;
                j_next    = j_reg + 1'b1;
                if (j_reg == n_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    if (mode_reg == inms_pkg::MODE_GREEDY || !bad_reg)
                    begin
                        cmd.capture = 1'b1;
                        cmd.emit    = pend_v_reg;
                        pend_v_next = 1'b1;
                    end
                    if (mode_reg == inms_pkg::MODE_GREEDY)
                    begin
                        j_next      = '0;
                        best_v_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                    else if ({1'b0, a_reg} == n_reg - 1'b1)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        a_next     = a_reg + 1'b1;
                        state_next = S_PICK;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                pend_v_next   = 1'b0;
                n_next        = '0;
                ovf_next      = 1'b0;
                vis_next      = '0;
                supp_next     = '0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            n_reg      <= '0;
            j_reg      <= '0;
            vd_reg     <= 1'b0;
            a_reg      <= '0;
            best_v_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            bad_reg    <= 1'b0;
            pend_v_reg <= 1'b0;
            vis_reg    <= '0;
            supp_reg   <= '0;
            mode_reg   <= inms_pkg::MODE_GREEDY;
            lim_reg    <= 16'd32768;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            j_reg      <= j_next;
            vd_reg     <= vd_next;
            a_reg      <= a_next;
            best_v_reg <= best_v_next;
            ovf_reg    <= ovf_next;
            bad_reg    <= bad_next;
            pend_v_reg <= pend_v_next;
            vis_reg    <= vis_next;
            supp_reg   <= supp_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    inms_pkg::REG_IOU_LIMIT: lim_reg  <= cfg_data;
                    inms_pkg::REG_MODE:      mode_reg <= cfg_data[0];
                    default:                 lim_reg  <= lim_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        jd_reg     <= j_reg[IW-1:0];
        best_reg   <= best_next;
        best_s_reg <= best_s_next;
    end

endmodule

// ----- rtl/iou_non_max_suppression.sv -----
// Greedy or per-class IoU non-maximum suppression over a buffered set of up
// to 64 boxes. Input: an item transfers when start is high and busy is low.
// A load item stores one box and busy stays low, so loads may come every
// cycle; boxes beyond 64 are dropped and flagged on the run's results.
// An end-of-set item raises busy and runs suppression. Greedy mode repeats a
// scan over the score store to pick the next box, then n overlap tests
// through a 7-stage pipeline. Class mode runs n overlap tests for each
// loaded box against all boxes. The two-port box store (two RAM copies)
// feeds the overlap pipeline. One result transfers per kept box on result,
// marked by result_valid for one cycle; the final one carries last_of_run,
// and an empty run gives one result with kept_valid low. The receiver
// cannot stall. Configuration writes transfer when cfg_valid is high
// (cfg_ready is always high) and must only be made while busy is low.
// Reset clears the box count, the flags and the registers to their defaults.
module iou_non_max_suppression (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  inms_pkg::item_t      item,
    output logic                 busy,
    output inms_pkg::result_t    result,
    output logic                 result_valid,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data
);

    inms_pkg::cmd_t  cmd;
    inms_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    inms_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .stat(stat), .cmd(cmd), .busy(busy)
    );

    inms_datapath u_datapath (
        .clk(clk), .rst_n(rst_n), .item(item), .cmd(cmd), .stat(stat),
        .result(result), .result_valid(result_valid)
    );

endmodule
